/* sv/rse_pkg.sv */
// Shared constants, codes and types of the RPN stack evaluator.
package rse_pkg;

  // Sizes
  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int VAL_W       = 32;
  localparam int MODE_W      = 2;
  localparam int NUM_W       = 15;
  localparam int OP_W        = 3;
  localparam int ST_W        = 3;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DVD_W       = VAL_W + FRAC_BITS;
  localparam int DCNT_W      = $clog2(DVD_W + 1);

  // Token kinds
  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

  // Operators
  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_MOD = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 3'd1;
  localparam logic [ST_W-1:0] ST_OVER  = 3'd2;
  localparam logic [ST_W-1:0] ST_DIVZ  = 3'd3;
  localparam logic [ST_W-1:0] ST_SAT   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [VAL_W-1:0] rem;
  } div_rsp_t;

endpackage

/* sv/rse_if.sv */
// Token and result channel interfaces of the RPN stack evaluator.
interface rse_tok_if;
  logic                       valid;
  logic                       ready;
  logic [rse_pkg::MODE_W-1:0] mode;
  logic [rse_pkg::NUM_W-1:0]  number;
  logic [rse_pkg::OP_W-1:0]   operator;

  modport source (output valid, output mode, output number, output operator, input ready);
  modport sink (input valid, input mode, input number, input operator, output ready);
endinterface

interface rse_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [rse_pkg::VAL_W-1:0] value;
  logic [rse_pkg::ST_W-1:0]         status;
  logic                             answer_ready;

  modport source (output valid, output value, output status, output answer_ready, input ready);
  modport sink (input valid, input value, input status, input answer_ready, output ready);
endinterface

/* sv/rse_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/rse_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module rse_div (
  input  logic              clk,
  input  logic              rst,
  input  rse_pkg::div_req_t req,
  output rse_pkg::div_rsp_t rsp
);

  logic                       busy;
  logic                       done;
  logic [rse_pkg::DCNT_W-1:0] cnt;
  logic [rse_pkg::DVD_W-1:0]  q;
  logic [rse_pkg::VAL_W-1:0]  rem;
  logic [rse_pkg::VAL_W-1:0]  dvs;
  logic [rse_pkg::VAL_W:0]    rem_sh;
  logic                       fits;

  // Shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem, q[rse_pkg::DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= rse_pkg::DCNT_W'(rse_pkg::DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == rse_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      q   <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= rse_pkg::VAL_W'(rem_sh - {1'b0, dvs});
        q   <= {q[rse_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[rse_pkg::VAL_W-1:0];
        q   <= {q[rse_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = q;
  assign rsp.rem  = rem;

endmodule

/* sv/rpn_stack_evaluator.sv */
// Top level of the RPN stack evaluator: operand stack, sequencer and arithmetic.
//
// Usage:
//   token  (sink)   : one request per token; mode picks push number, apply operator
//                     or end of expression. ready is high while no token is in work.
//   result (source) : exactly one result per token: value (signed Q16.16), sticky
//                     status, and answer_ready set for the result of an end token.
// Path from token accept to the output register, by state (DVD_W = 48 at Q16.16):
//   push, end, underflow, unknown codes : straight to EMIT
//   add, subtract                      : READ, EXEC, EMIT
//   multiply                           : READ, EXEC, MUL, EMIT
//   divide, modulo                     : READ, EXEC, DIV, EMIT, DIV waiting on the
//                                        shared divider retiring one quotient bit a cycle
// One token is in work at a time, so the next token is taken in the cycle after the
// previous result enters the output register. The top of stack sits in a register;
// deeper entries live in a RAM with registered read data.
// Reset empties the stack and clears the last value and status; no clearing pass.
// A stalled result holds in the output register; the block then waits to emit the
// following result but keeps its state.
module rpn_stack_evaluator (
  input logic        clk,
  input logic        rst,
  rse_tok_if.sink    token,
  rse_res_if.source  result
);

  typedef struct packed {
    logic                      sat;
    logic [rse_pkg::VAL_W-1:0] v;
  } clamp_t;

  localparam logic [63:0] MAG_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MAG_MIN = 64'h0000_0000_8000_0000;
  localparam logic [rse_pkg::VAL_W-1:0] VAL_MAX = {1'b0, {(rse_pkg::VAL_W-1){1'b1}}};
  localparam logic [rse_pkg::VAL_W-1:0] VAL_MIN = {1'b1, {(rse_pkg::VAL_W-1){1'b0}}};

  // Clamp a sign and magnitude to the value range
  function automatic clamp_t clamp_mag(input logic neg, input logic [63:0] mag);
    clamp_t c;
    c.sat = 1'b0;
    if (neg) begin
      if (mag > MAG_MIN) begin
        c.sat = 1'b1;
        c.v   = VAL_MIN;
      end else begin
        c.v = rse_pkg::VAL_W'(~mag[rse_pkg::VAL_W-1:0] + 1'b1);
      end
    end else if (mag > MAG_MAX) begin
      c.sat = 1'b1;
      c.v   = VAL_MAX;
    end else begin
      c.v = mag[rse_pkg::VAL_W-1:0];
    end
    return c;
  endfunction

  rse_pkg::state_t state, state_next;

  logic [rse_pkg::CNT_W-1:0] count, count_next;
  logic [rse_pkg::VAL_W-1:0] tos, tos_next;
  logic [rse_pkg::VAL_W-1:0] last_value, last_value_next;
  logic [rse_pkg::ST_W-1:0]  err, err_next;
  logic [rse_pkg::OP_W-1:0]  op_reg, op_reg_next;
  logic [rse_pkg::VAL_W-1:0] a_reg, a_reg_next;
  logic [63:0]               prod, prod_next;
  logic [rse_pkg::VAL_W-1:0] res_value, res_value_next;
  logic [rse_pkg::ST_W-1:0]  res_status, res_status_next;
  logic                      res_ans, res_ans_next;
  logic                      ovalid;
  logic [rse_pkg::VAL_W-1:0] ovalue;
  logic [rse_pkg::ST_W-1:0]  ostatus;
  logic                      oans;
  logic                      load_out;

  // Stack RAM ports
  logic                       ram_we;
  logic [rse_pkg::ADDR_W-1:0] ram_waddr;
  logic [rse_pkg::ADDR_W-1:0] ram_raddr;
  logic [rse_pkg::VAL_W-1:0]  ram_rdata;
  logic [rse_pkg::CNT_W-1:0]  cnt_m1;
  logic [rse_pkg::CNT_W-1:0]  cnt_m2;

  // Divider
  rse_pkg::div_req_t div_req;
  rse_pkg::div_rsp_t div_rsp;
  logic              div_start;

  // Operand views
  logic                      na, nb;
  logic [rse_pkg::VAL_W-1:0] ma, mb, ib;
  logic [rse_pkg::VAL_W:0]   sum;
  logic [63:0]               push_mag;
  logic                      push_sat;
  logic [rse_pkg::VAL_W-1:0] push_val;

  // Result of an operator
  logic                      fin;
  logic [rse_pkg::VAL_W-1:0] fin_r;
  logic                      fin_sat;
  logic                      fin_divz;
  clamp_t                    cl;

  assign cnt_m1    = count - rse_pkg::CNT_W'(1);
  assign cnt_m2    = count - rse_pkg::CNT_W'(2);
  assign ram_waddr = cnt_m1[rse_pkg::ADDR_W-1:0];
  assign ram_raddr = cnt_m2[rse_pkg::ADDR_W-1:0];

  rse_ram #(
    .WIDTH (rse_pkg::VAL_W),
    .DEPTH (rse_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tos),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rse_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // a is the deeper operand, b the top of stack
  assign na  = a_reg[rse_pkg::VAL_W-1];
  assign nb  = tos[rse_pkg::VAL_W-1];
  assign ma  = na ? (~a_reg + 1'b1) : a_reg;
  assign mb  = nb ? (~tos + 1'b1) : tos;
  assign ib  = mb >> rse_pkg::FRAC_BITS;
  assign sum = (op_reg == rse_pkg::OP_SUB) ?
               ({a_reg[rse_pkg::VAL_W-1], a_reg} - {tos[rse_pkg::VAL_W-1], tos}) :
               ({a_reg[rse_pkg::VAL_W-1], a_reg} + {tos[rse_pkg::VAL_W-1], tos});

  // Pushed number in fixed point
  assign push_mag = 64'(token.number) << rse_pkg::FRAC_BITS;
  assign push_sat = push_mag > MAG_MAX;
  assign push_val = push_sat ? VAL_MAX : push_mag[rse_pkg::VAL_W-1:0];

  // Divider operands
  assign div_req.start    = div_start;
  assign div_req.dividend = (op_reg == rse_pkg::OP_DIV) ?
                            (rse_pkg::DVD_W'(ma) << rse_pkg::FRAC_BITS) :
                            rse_pkg::DVD_W'(ma >> rse_pkg::FRAC_BITS);
  assign div_req.divisor  = (op_reg == rse_pkg::OP_DIV) ? mb : ib;

  assign token.ready = (state == rse_pkg::S_IDLE);
  assign load_out    = (state == rse_pkg::S_EMIT) && (!ovalid || result.ready);

  // Sequencer: next state and datapath updates
  always_comb begin
    state_next      = state;
    count_next      = count;
    tos_next        = tos;
    last_value_next = last_value;
    err_next        = err;
    op_reg_next     = op_reg;
    a_reg_next      = a_reg;
    prod_next       = prod;
    res_value_next  = res_value;
    res_status_next = res_status;
    res_ans_next    = res_ans;
    ram_we          = 1'b0;
    div_start       = 1'b0;
    fin             = 1'b0;
    fin_r           = '0;
    fin_sat         = 1'b0;
    fin_divz        = 1'b0;
    cl              = '0;

    case (state)
      rse_pkg::S_IDLE: begin
        if (token.valid) begin
          res_value_next  = last_value;
          res_status_next = err;
          res_ans_next    = 1'b0;
          state_next      = rse_pkg::S_EMIT;
          case (token.mode)
            rse_pkg::MODE_PUSH: begin
              res_value_next = push_val;
              if (push_sat && err == rse_pkg::ST_OK) begin
                err_next = rse_pkg::ST_SAT;
              end
              if (count == rse_pkg::CNT_W'(rse_pkg::STACK_DEPTH)) begin
                if (!push_sat && err == rse_pkg::ST_OK) begin
                  err_next = rse_pkg::ST_OVER;
                end
              end else begin
                // spill the old top into the RAM
                ram_we     = (count != '0);
                tos_next   = push_val;
                count_next = count + rse_pkg::CNT_W'(1);
              end
              res_status_next = err_next;
            end
            rse_pkg::MODE_OP: begin
              if (token.operator <= rse_pkg::OP_MOD) begin
                if (count < rse_pkg::CNT_W'(2)) begin
                  if (err == rse_pkg::ST_OK) begin
                    err_next = rse_pkg::ST_UNDER;
                  end
                  res_status_next = err_next;
                end else begin
                  op_reg_next = token.operator;
                  state_next  = rse_pkg::S_READ;
                end
              end
            end
            rse_pkg::MODE_END: begin
              res_ans_next    = 1'b1;
              count_next      = '0;
              last_value_next = '0;
              err_next        = rse_pkg::ST_OK;
            end
            default: begin
            end
          endcase
        end
      end

      rse_pkg::S_READ: begin
        a_reg_next = ram_rdata;
        state_next = rse_pkg::S_EXEC;
      end

      rse_pkg::S_EXEC: begin
        case (op_reg)
          rse_pkg::OP_ADD, rse_pkg::OP_SUB: begin
            fin = 1'b1;
            if (sum[rse_pkg::VAL_W] != sum[rse_pkg::VAL_W-1]) begin
              fin_sat = 1'b1;
              fin_r   = sum[rse_pkg::VAL_W] ? VAL_MIN : VAL_MAX;
            end else begin
              fin_r = sum[rse_pkg::VAL_W-1:0];
            end
          end
          rse_pkg::OP_MUL: begin
            prod_next  = 64'(ma) * 64'(mb);
            state_next = rse_pkg::S_MUL;
          end
          rse_pkg::OP_DIV: begin
            if (mb == '0) begin
              fin      = 1'b1;
              fin_divz = 1'b1;
              if (a_reg == '0) begin
                fin_r = '0;
              end else begin
                fin_r = na ? VAL_MIN : VAL_MAX;
              end
            end else begin
              div_start  = 1'b1;
              state_next = rse_pkg::S_DIV;
            end
          end
          default: begin
            if (ib == '0) begin
              fin      = 1'b1;
              fin_divz = 1'b1;
              fin_r    = '0;
            end else begin
              div_start  = 1'b1;
              state_next = rse_pkg::S_DIV;
            end
          end
        endcase
      end

      rse_pkg::S_MUL: begin
        cl      = clamp_mag(na ^ nb, prod >> rse_pkg::FRAC_BITS);
        fin     = 1'b1;
        fin_r   = cl.v;
        fin_sat = cl.sat;
      end

      rse_pkg::S_DIV: begin
        if (div_rsp.done) begin
          if (op_reg == rse_pkg::OP_DIV) begin
            cl = clamp_mag(na ^ nb, 64'(div_rsp.quot));
          end else begin
            cl = clamp_mag(na, 64'(div_rsp.rem) << rse_pkg::FRAC_BITS);
          end
          fin     = 1'b1;
          fin_r   = cl.v;
          fin_sat = cl.sat;
        end
      end

      rse_pkg::S_EMIT: begin
        if (!ovalid || result.ready) begin
          state_next = rse_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = rse_pkg::S_IDLE;
      end
    endcase

    // Commit an operator result: pop two, push one
    if (fin) begin
      tos_next        = fin_r;
      count_next      = cnt_m1;
      last_value_next = fin_r;
      if (err == rse_pkg::ST_OK) begin
        if (fin_divz) begin
          err_next = rse_pkg::ST_DIVZ;
        end else if (fin_sat) begin
          err_next = rse_pkg::ST_SAT;
        end
      end
      res_value_next  = fin_r;
      res_status_next = err_next;
      res_ans_next    = 1'b0;
      state_next      = rse_pkg::S_EMIT;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rse_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      last_value <= '0;
      err        <= rse_pkg::ST_OK;
      ovalid     <= 1'b0;
    end else begin
      count      <= count_next;
      last_value <= last_value_next;
      err        <= err_next;
      if (load_out) begin
        ovalid <= 1'b1;
      end else if (result.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tos        <= tos_next;
    op_reg     <= op_reg_next;
    a_reg      <= a_reg_next;
    prod       <= prod_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    res_ans    <= res_ans_next;
    if (load_out) begin
      ovalue  <= res_value;
      ostatus <= res_status;
      oans    <= res_ans;
    end
  end

  assign result.valid        = ovalid;
  assign result.value        = ovalue;
  assign result.status       = ostatus;
  assign result.answer_ready = oans;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rse_pkg::CNT_W'(rse_pkg::STACK_DEPTH))
    else $error("stack count above depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    token.valid && token.ready |=> state != rse_pkg::S_IDLE)
    else $error("accepted token did not start work");

  a_div_active: assert property (@(posedge clk) disable iff (rst)
    state == rse_pkg::S_DIV |-> div_rsp.busy || div_rsp.done)
    else $error("waiting on an idle divider");

  a_end_empties: assert property (@(posedge clk) disable iff (rst)
    state == rse_pkg::S_EMIT && res_ans |-> count == '0 && err == rse_pkg::ST_OK)
    else $error("end token left stack or status behind");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> ostatus <= rse_pkg::ST_SAT)
    else $error("status code out of range");
`endif

endmodule
